// File: sv/cross_min_max_filter_assert.svh
// Assertion macros used by the cross min/max filter result buffer.
`ifndef CROSS_MIN_MAX_FILTER_ASSERT_SVH
`define CROSS_MIN_MAX_FILTER_ASSERT_SVH

// Checks that cons holds in the same cycle as ante.
`define CMMF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Checks that cons holds in the cycle after ante.
`define CMMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/cmmf_pkg.sv
// Types, constants and the min/max helper of the cross min/max filter.
`timescale 1ns / 1ps
`default_nettype none

package cmmf_pkg;

    localparam int PIXEL_W     = 32;
    localparam int HEIGHT_W    = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_WIDTH_W = 11;
    localparam int MAX_RESULTS = 3;
    localparam int CNT_W       = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic MODE_ERODE  = 1'b0;
    localparam logic MODE_DILATE = 1'b1;

    typedef logic [PIXEL_W-1:0] pixel_t;

    typedef struct packed {
        pixel_t older;
        pixel_t newer;
    } line_pair_t;

    typedef struct packed {
        logic row_out;
        logic has_up;
        logic has_left;
        logic has_right;
        logic has_far_left;
        logic last_row_out;
        logic frame_end;
    } kern_flags_t;

    typedef struct packed {
        logic [CNT_W-1:0]                   count;
        logic                               eof;
        logic [MAX_RESULTS-1:0][PIXEL_W-1:0] pix;
    } result_set_t;

    function automatic pixel_t pick(logic mode, pixel_t a, pixel_t b);
        if (mode == MODE_DILATE)
            return (a > b) ? a : b;
        return (a < b) ? a : b;
    endfunction

endpackage

`default_nettype wire

// File: sv/cmmf_line_store.sv
// Line store memory holding the two previous rows as one pair per column.
`timescale 1ns / 1ps
`default_nettype none

module cmmf_line_store
    import cmmf_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire line_pair_t    wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr0,
    input  wire logic [AW-1:0] raddr1,
    output line_pair_t         rdata0,
    output line_pair_t         rdata1
);

    line_pair_t mem [DEPTH];
    line_pair_t rdata0_reg;
    line_pair_t rdata1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata0_reg <= mem[raddr0];
            rdata1_reg <= mem[raddr1];
        end
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

`default_nettype wire

// File: sv/cmmf_kernel.sv
// Cross-shaped min/max kernel that forms the results of one input pixel.
`timescale 1ns / 1ps
`default_nettype none

module cmmf_kernel
    import cmmf_pkg::*;
(
    input  wire logic        mode,
    input  wire kern_flags_t flags,
    input  wire pixel_t      below,
    input  wire pixel_t      center,
    input  wire pixel_t      up,
    input  wire pixel_t      right,
    input  wire pixel_t      left,
    input  wire pixel_t      pend0,
    input  wire pixel_t      pend1,
    output result_set_t      results
);

    pixel_t a1;
    pixel_t b1;
    pixel_t c1;
    pixel_t r1;
    pixel_t a2;
    pixel_t b2;
    pixel_t r2;
    pixel_t r3;

    // An absent neighbor is replaced by a value already in the set.
    always_comb
    begin
        a1 = pick(mode, center, below);
        b1 = pick(mode, flags.has_left ? left : center, flags.has_right ? right : center);
        c1 = pick(mode, a1, b1);
        r1 = pick(mode, c1, flags.has_up ? up : center);
        a2 = pick(mode, pend0, below);
        b2 = pick(mode, flags.has_far_left ? pend1 : pend0, left);
        r2 = pick(mode, a2, b2);
        r3 = pick(mode, pick(mode, below, pend0), center);
    end

    always_comb
    begin
        logic [CNT_W-1:0] n;
        n = '0;
        results = '0;
        if (flags.row_out)
        begin
            results.pix[n] = r1;
            n = n + CNT_W'(1);
        end
        if (flags.last_row_out)
        begin
            results.pix[n] = r2;
            n = n + CNT_W'(1);
        end
        if (flags.frame_end)
        begin
            results.pix[n] = r3;
            n = n + CNT_W'(1);
        end
        results.count = n;
        results.eof   = flags.frame_end;
    end

endmodule

`default_nettype wire

// File: sv/cmmf_result_buf.sv
// Output buffer that holds the results of one pixel and sends them one beat at a time.
`timescale 1ns / 1ps
`default_nettype none
`include "cross_min_max_filter_assert.svh"

module cmmf_result_buf
    import cmmf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire result_set_t results,
    output logic             take,
    output logic             out_valid,
    input  wire logic        out_stall,
    output pixel_t           pixel_out,
    output logic             last_of_run,
    output logic             end_of_frame
);

    logic             valid_reg;
    logic             valid_next;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    result_set_t      set_reg;
    logic             last_beat;
    logic             beat_done;

    assign last_beat = idx_reg == (set_reg.count - CNT_W'(1));
    assign beat_done = valid_reg && !out_stall;
    assign take      = !valid_reg || (beat_done && last_beat);

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (take)
        begin
            valid_next = load && (results.count != '0);
            idx_next   = '0;
        end
        else if (beat_done)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && load)
        begin
            set_reg <= results;
        end
    end

    assign out_valid    = valid_reg;
    assign pixel_out    = set_reg.pix[idx_reg];
    assign last_of_run  = last_beat;
    assign end_of_frame = set_reg.eof && last_beat;

    `CMMF_ASSERT_SAME(a_idx_in_range, valid_reg, idx_reg < set_reg.count, "beat index past count")
    `CMMF_ASSERT_SAME(a_eof_is_last, valid_reg && end_of_frame, last_of_run, "frame end not last")
    `CMMF_ASSERT_NEXT(a_run_continues, beat_done && !last_beat,
        valid_reg && (idx_reg == $past(idx_reg) + CNT_W'(1)), "run cut short")

endmodule

`default_nettype wire

// File: sv/cross_min_max_filter.sv
// Top level of the streaming 3x3 cross erode/dilate filter.
`timescale 1ns / 1ps
`default_nettype none

// Streaming cross-shaped erode (minimum) or dilate (maximum) over a frame of 32-bit
// pixels in raster order. Each input pixel is registered together with a two-port
// read of the line store, and the results it causes are formed in the next cycle
// and held in an output buffer that sends one beat per cycle while out_stall is
// low. Outside the last row a pixel is accepted every cycle unless the output
// stalls. On the last row a pixel after the first column yields two results (three
// on the last column), so the single result port stalls the input there. Output
// row r comes out while input row r+1 arrives; input row 0 gives no beat. Any
// register write restarts the frame and should be made only while the block is
// drained. Widths are taken from the low 11 bits of cfg_data; beyond MAX_WIDTH
// they act as MAX_WIDTH, widths and heights below 2 act as 2.
module cross_min_max_filter
    import cmmf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [PIXEL_W-1:0]   pixel_in,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [PIXEL_W-1:0]        pixel_out,
    output logic                      last_of_run,
    output logic                      end_of_frame
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int EW = (XW + 1 > CFG_WIDTH_W) ? XW + 1 : CFG_WIDTH_W;

    logic                mode_reg;
    logic [XW-1:0]       last_col_reg;
    logic [HEIGHT_W-1:0] last_row_reg;
    logic [EW-1:0]       width_ext;
    logic [EW-1:0]       width_eff;
    logic [HEIGHT_W-1:0] height_val;
    logic                cfg_hit;

    logic [XW-1:0]       x_reg;
    logic [XW-1:0]       x_next;
    logic [HEIGHT_W-1:0] y_reg;
    logic [HEIGHT_W-1:0] y_next;
    pixel_t              pend0_reg;
    pixel_t              pend0_next;
    pixel_t              pend1_reg;
    pixel_t              pend1_next;

    logic                in_accept;
    logic                x_last;
    logic                y_last;
    kern_flags_t         flags_a;
    logic [XW-1:0]       raddr1;

    logic                valid_b_reg;
    pixel_t              p_b_reg;
    logic [XW-1:0]       x_b_reg;
    kern_flags_t         flags_b_reg;
    pixel_t              pend0_b_reg;
    pixel_t              pend1_b_reg;
    logic                fwd0_reg;
    logic                fwd1_reg;
    line_pair_t          fwd_data_reg;
    pixel_t              left_reg;

    line_pair_t          rd0;
    line_pair_t          rd1;
    line_pair_t          pair0;
    pixel_t              right_px;
    line_pair_t          wdata;
    logic                b_move;
    logic                buf_take;
    result_set_t         results;

    // Configuration decode into effective limits.
    assign width_ext  = EW'(cfg_data[CFG_WIDTH_W-1:0]);
    assign height_val = cfg_data[HEIGHT_W-1:0];
    assign cfg_hit    = cfg_we && (cfg_index == REG_FILTER_MODE
                        || cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

    always_comb
    begin
        priority if (width_ext < EW'(2))
            width_eff = EW'(2);
        else if (width_ext > EW'(MAX_WIDTH))
            width_eff = EW'(MAX_WIDTH);
        else
            width_eff = width_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_ERODE;
            last_col_reg <= XW'(1);
            last_row_reg <= HEIGHT_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FILTER_MODE:  mode_reg <= cfg_data[0];
                REG_IMAGE_WIDTH:  last_col_reg <= XW'(width_eff - EW'(1));
                REG_IMAGE_HEIGHT: last_row_reg <= (height_val < HEIGHT_W'(2))
                                                  ? HEIGHT_W'(1) : height_val - HEIGHT_W'(1);
                default:          ;
            endcase
        end
    end

    // Input position and the last-row pixel history.
    assign in_accept = in_valid && !in_stall;
    assign x_last    = x_reg == last_col_reg;
    assign y_last    = y_reg == last_row_reg;

    always_comb
    begin
        flags_a.row_out      = y_reg != '0;
        flags_a.has_up       = y_reg >= HEIGHT_W'(2);
        flags_a.has_left     = x_reg != '0;
        flags_a.has_right    = !x_last;
        flags_a.has_far_left = {1'b0, x_reg} >= (XW + 1)'(2);
        flags_a.last_row_out = y_last && (x_reg != '0);
        flags_a.frame_end    = y_last && x_last;
    end

    always_comb
    begin
        x_next     = x_reg;
        y_next     = y_reg;
        pend0_next = pend0_reg;
        pend1_next = pend1_reg;
        if (cfg_hit)
        begin
            x_next     = '0;
            y_next     = '0;
            pend0_next = '0;
            pend1_next = '0;
        end
        else if (in_accept)
        begin
            if (x_last)
            begin
                x_next     = '0;
                y_next     = y_last ? '0 : y_reg + HEIGHT_W'(1);
                pend0_next = '0;
                pend1_next = '0;
            end
            else
            begin
                x_next     = x_reg + XW'(1);
                pend1_next = pend0_reg;
                pend0_next = pixel_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg     <= '0;
            y_reg     <= '0;
            pend0_reg <= '0;
            pend1_reg <= '0;
        end
        else
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            pend0_reg <= pend0_next;
            pend1_reg <= pend1_next;
        end
    end

    // Line store: read the pixel's column and the one to its right at acceptance,
    // write the updated pair back when the pixel leaves the second stage.
    assign raddr1 = x_last ? x_reg : x_reg + XW'(1);
    assign b_move = valid_b_reg && buf_take;
    assign in_stall = valid_b_reg && !b_move;

    assign pair0    = fwd0_reg ? fwd_data_reg : rd0;
    assign right_px = fwd1_reg ? fwd_data_reg.newer : rd1.newer;
    assign wdata    = '{older: pair0.newer, newer: p_b_reg};

    cmmf_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (XW)
    ) u_line_store (
        .clk    (clk),
        .we     (b_move),
        .waddr  (x_b_reg),
        .wdata  (wdata),
        .re     (in_accept),
        .raddr0 (x_reg),
        .raddr1 (raddr1),
        .rdata0 (rd0),
        .rdata1 (rd1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_b_reg <= 1'b0;
            fwd0_reg    <= 1'b0;
            fwd1_reg    <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                valid_b_reg <= 1'b1;
                fwd0_reg    <= b_move && (x_b_reg == x_reg);
                fwd1_reg    <= b_move && (x_b_reg == raddr1);
            end
            else if (b_move)
            begin
                valid_b_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            p_b_reg      <= pixel_in;
            x_b_reg      <= x_reg;
            flags_b_reg  <= flags_a;
            pend0_b_reg  <= pend0_reg;
            pend1_b_reg  <= pend1_reg;
            fwd_data_reg <= wdata;
        end
        if (b_move)
        begin
            left_reg <= pair0.newer;
        end
    end

    cmmf_kernel u_kernel (
        .mode    (mode_reg),
        .flags   (flags_b_reg),
        .below   (p_b_reg),
        .center  (pair0.newer),
        .up      (pair0.older),
        .right   (right_px),
        .left    (left_reg),
        .pend0   (pend0_b_reg),
        .pend1   (pend1_b_reg),
        .results (results)
    );

    cmmf_result_buf u_result_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (valid_b_reg),
        .results      (results),
        .take         (buf_take),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_out    (pixel_out),
        .last_of_run  (last_of_run),
        .end_of_frame (end_of_frame)
    );

endmodule

`default_nettype wire
